// ===== hdl/wtnm_pkg.sv =====
package wtnm_pkg;

  localparam int MAX_ROTORS  = 8;
  localparam int TABLE_DEPTH = 4 * MAX_ROTORS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int ROT_W       = $clog2(MAX_ROTORS + 1);
  localparam int COEF_W      = 48;
  localparam int WRENCH_W    = 32;
  localparam int OUT_W       = 32;
  localparam int CFG_IDX_W   = 3;

  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_MIX    = 2'd1;
  localparam logic [1:0] KIND_WRENCH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTOR_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_A2      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_A1      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_A0      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_MAX     = 3'd5;

  localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] I32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] I32_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [1:0] {SH_8, SH_16, SH_24} shift_sel_t;

  typedef enum logic [1:0] {PH_SETTLE, PH_START, PH_WAIT} phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC_MUL, S_SQRT, S_OMSQ, S_A2, S_A1, S_ADD0, S_ADD1,
    S_DIV, S_MIX_MUL, S_DONE
  } seq_state_t;

  typedef struct packed {
    logic       start;
    shift_sel_t shift;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } unit_rsp_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] val;
  } sum_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } clamp_t;

  function automatic logic signed [63:0] ext48(input logic [47:0] v);
    return $signed({{16{v[47]}}, v});
  endfunction

  function automatic logic signed [63:0] ext32(input logic [31:0] v);
    return $signed({{32{v[31]}}, v});
  endfunction

  function automatic sum_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b);
    logic [64:0] s;
    sum_t        r;
    s     = {a[63], a} + {b[63], b};
    r.sat = s[64] ^ s[63];
    r.val = r.sat ? (s[64] ? I64_MIN : I64_MAX) : s[63:0];
    return r;
  endfunction

  function automatic clamp_t clamp32(input logic signed [63:0] v);
    clamp_t r;
    r.sat = 1'b0;
    r.val = v[31:0];
    if (v > I32_MAX) begin
      r.sat = 1'b1;
      r.val = I32_MAX[31:0];
    end else if (v < I32_MIN) begin
      r.sat = 1'b1;
      r.val = I32_MIN[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/wtnm_mul.sv =====
module wtnm_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  wtnm_pkg::mul_req_t  req,
  input  logic signed [63:0]  op_a,
  input  logic signed [63:0]  op_b,
  output wtnm_pkg::unit_rsp_t rsp,
  output logic signed [63:0]  prod
);
  import wtnm_pkg::*;

  logic         busy_r;
  logic         done_r;
  logic [2:0]   k_r;
  logic [63:0]  ma_r;
  logic [63:0]  mb_r;
  logic         neg_r;
  shift_sel_t   sh_r;
  logic [63:0]  pp_r;
  logic [127:0] acc_r;
  logic [63:0]  prod_r;
  logic         sat_r;

  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [63:0]  pp_nxt;
  logic [1:0]   kp;
  logic [1:0]   offs;
  logic [127:0] pp_sh;
  logic [127:0] q;
  logic         rem_nz;
  logic [127:0] qr;
  logic [127:0] limit;
  logic         ovf;
  logic [63:0]  res;
  logic         take;

  assign take   = req.start && !busy_r;
  assign a_half = k_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign b_half = k_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign pp_nxt = a_half * b_half;
  assign kp     = k_r[1:0] - 2'd1;
  assign offs   = {1'b0, kp[1]} + {1'b0, kp[0]};

  always_comb begin
    unique case (offs)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      2'd2:    pp_sh = {pp_r, 64'd0};
      default: pp_sh = '0;
    endcase
  end

  always_comb begin
    unique case (sh_r)
      SH_8: begin
        q      = acc_r >> 8;
        rem_nz = |acc_r[7:0];
      end
      SH_16: begin
        q      = acc_r >> 16;
        rem_nz = |acc_r[15:0];
      end
      SH_24: begin
        q      = acc_r >> 24;
        rem_nz = |acc_r[23:0];
      end
      default: begin
        q      = acc_r >> 24;
        rem_nz = |acc_r[23:0];
      end
    endcase
    qr    = q + {127'd0, neg_r & rem_nz};
    limit = neg_r ? {64'd0, 1'b1, 63'd0} : {64'd0, 1'b0, {63{1'b1}}};
    ovf   = qr > limit;
    if (ovf) begin
      res = neg_r ? I64_MIN : I64_MAX;
    end else begin
      res = neg_r ? (64'd0 - qr[63:0]) : qr[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (take) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r) begin
        k_r <= k_r + 3'd1;
        if (k_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ma_r  <= op_a[63] ? (64'd0 - op_a) : op_a;
      mb_r  <= op_b[63] ? (64'd0 - op_b) : op_b;
      neg_r <= op_a[63] ^ op_b[63];
      sh_r  <= req.shift;
      acc_r <= '0;
    end else if (busy_r) begin
      if (k_r <= 3'd3) begin
        pp_r <= pp_nxt;
      end
      if (k_r >= 3'd1 && k_r <= 3'd4) begin
        acc_r <= acc_r + pp_sh;
      end
      if (k_r == 3'd5) begin
        prod_r <= res;
        sat_r  <= ovf;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign prod     = prod_r;

endmodule

// ===== hdl/wtnm_sqrt.sv =====
module wtnm_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import wtnm_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] t;
  logic        ge;
  logic        take;

  assign take = start && !busy_r;
  assign t    = res_r + bit_r;
  assign ge   = v_r >= t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (take) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      v_r   <= radicand;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (ge) begin
        v_r   <= v_r - t;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

// ===== hdl/wtnm_div.sv =====
module wtnm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [63:0]  num,
  input  logic signed [63:0]  den,
  output wtnm_pkg::unit_rsp_t rsp,
  output logic signed [63:0]  quot
);
  import wtnm_pkg::*;

  localparam int DVD_W = 88;
  localparam int DEN_W = 49;

  logic             busy_r;
  logic             done_r;
  logic [6:0]       cnt_r;
  logic [DEN_W-1:0] ud_r;
  logic [DEN_W-1:0] rem_r;
  logic [DVD_W-1:0] dvd_r;
  logic             neg_r;
  logic [63:0]      quot_r;
  logic             sat_r;

  logic [63:0]      un;
  logic [63:0]      ud;
  logic [DEN_W:0]   t;
  logic [DEN_W:0]   t_sub;
  logic             ge;
  logic             ovf;
  logic             take;

  assign take  = start && !busy_r;
  assign un    = num[63] ? (64'd0 - num) : num;
  assign ud    = den[63] ? (64'd0 - den) : den;
  assign t     = {rem_r, dvd_r[DVD_W-1]};
  assign t_sub = t - {1'b0, ud_r};
  assign ge    = t >= {1'b0, ud_r};
  assign ovf   = |dvd_r[DVD_W-1:63];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (take) begin
        cnt_r <= '0;
        if (den == 64'sd0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(DVD_W)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ud_r   <= ud[DEN_W-1:0];
      rem_r  <= '0;
      dvd_r  <= {un, 24'd0};
      neg_r  <= num[63] ^ den[63];
      quot_r <= '0;
      sat_r  <= (den == 64'sd0);
    end else if (busy_r) begin
      if (cnt_r < 7'(DVD_W)) begin
        rem_r <= ge ? t_sub[DEN_W-1:0] : t[DEN_W-1:0];
        dvd_r <= {dvd_r[DVD_W-2:0], ge};
      end else begin
        sat_r <= ovf;
        if (ovf) begin
          quot_r <= neg_r ? (64'd0 - I64_MAX) : I64_MAX;
        end else begin
          quot_r <= neg_r ? (64'd0 - dvd_r[63:0]) : dvd_r[63:0];
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign quot     = quot_r;

endmodule

// ===== hdl/wrench_to_normalized_mix_unit.sv =====
// Maps a wrench through the stored allocation matrix, a per-rotor square root and
// PWM model, and the stored mixing matrix into a saturated normalized wrench.
// Coefficient write transactions (kinds 0 and 1) are taken while idle and give no
// result; the tables must be written before a wrench is sent. For each of the N
// rotors in use, a wrench transaction runs eleven products on the shared multiplier
// (one 32x32 partial product per cycle), the bit-serial square root, the bit-serial
// throttle divider (which skips its iterations and flags saturation when the PWM span
// is zero) and the two PWM offset sums. The block takes a new transaction only
// when the previous one is finished, while its result may still wait in the output
// register.
module wrench_to_normalized_mix_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wtnm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wtnm_pkg::COEF_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_kind,
  input  logic [4:0]                          in_coef_index,
  input  logic signed [wtnm_pkg::COEF_W-1:0]  in_coef_value,
  input  logic signed [wtnm_pkg::WRENCH_W-1:0] in_roll_torque,
  input  logic signed [wtnm_pkg::WRENCH_W-1:0] in_pitch_torque,
  input  logic signed [wtnm_pkg::WRENCH_W-1:0] in_yaw_torque,
  input  logic signed [wtnm_pkg::WRENCH_W-1:0] in_thrust_force,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wtnm_pkg::OUT_W-1:0]   out_norm_roll,
  output logic signed [wtnm_pkg::OUT_W-1:0]   out_norm_pitch,
  output logic signed [wtnm_pkg::OUT_W-1:0]   out_norm_yaw,
  output logic signed [wtnm_pkg::OUT_W-1:0]   out_norm_thrust,
  output logic                                out_saturated
);
  import wtnm_pkg::*;

  logic [3:0]         rotor_count_r;
  logic [COEF_W-1:0]  pwm_a2_r;
  logic [COEF_W-1:0]  pwm_a1_r;
  logic [COEF_W-1:0]  pwm_a0_r;
  logic [COEF_W-1:0]  pwm_min_r;
  logic [COEF_W-1:0]  pwm_max_r;

  seq_state_t         state_r;
  seq_state_t         state_nxt;
  phase_t             phase_r;
  phase_t             phase_nxt;

  logic [COEF_W-1:0]  alloc_mem [TABLE_DEPTH];
  logic [COEF_W-1:0]  mix_mem [TABLE_DEPTH];
  logic [COEF_W-1:0]  alloc_rd_r;
  logic [COEF_W-1:0]  mix_rd_r;

  logic [WRENCH_W-1:0] w_r [4];
  logic [ROT_W-1:0]   n_r;
  logic [ROT_W-1:0]   r_r;
  logic [1:0]         c_r;
  logic signed [63:0] den_r;
  logic signed [63:0] sq_r;
  logic [31:0]        om_r;
  logic signed [63:0] omsq_r;
  logic signed [63:0] pwm_r;
  logic signed [63:0] thr_r;
  logic signed [63:0] acc_r [4];
  logic               sat_r;

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_roll_r;
  logic [OUT_W-1:0]   out_pitch_r;
  logic [OUT_W-1:0]   out_yaw_r;
  logic [OUT_W-1:0]   out_thrust_r;
  logic               out_sat_r;

  mul_req_t           mul_req;
  unit_rsp_t          mul_rsp;
  logic signed [63:0] mul_a;
  logic signed [63:0] mul_b;
  logic signed [63:0] mul_p;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;
  logic               div_start;
  unit_rsp_t          div_rsp;
  logic signed [63:0] div_q;

  logic               accept;
  logic               issue;
  logic               unit_done;
  logic               last_rotor;
  logic               out_load;
  logic [ROT_W-1:0]   n_in;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic               idx_ok;
  sum_t               s_sum;
  clamp_t             cl_roll;
  clamp_t             cl_pitch;
  clamp_t             cl_yaw;
  clamp_t             cl_thrust;

  assign accept     = in_valid && in_ready;
  assign issue      = (phase_r == PH_START);
  assign last_rotor = (ROT_W'(r_r + 1'b1) == n_r);
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign n_in       = (int'(rotor_count_r) > MAX_ROTORS) ? ROT_W'(MAX_ROTORS)
                                                         : ROT_W'(rotor_count_r);
  assign rd_addr    = ADDR_W'({r_r, c_r});
  assign wr_addr    = ADDR_W'(in_coef_index);
  assign idx_ok     = int'(in_coef_index) < TABLE_DEPTH;

  wtnm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .rsp   (mul_rsp),
    .prod  (mul_p)
  );

  wtnm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sq_r[63] ? 64'd0 : sq_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  wtnm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (pwm_r),
    .den   (den_r),
    .rsp   (div_rsp),
    .quot  (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_kind == KIND_WRENCH) begin
          state_nxt = (n_in == '0) ? S_DONE : S_ALLOC_MUL;
          phase_nxt = PH_SETTLE;
        end
      end
      S_ADD0: state_nxt = S_ADD1;
      S_ADD1: begin
        state_nxt = S_DIV;
        phase_nxt = PH_SETTLE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        unique case (phase_r)
          PH_SETTLE: phase_nxt = PH_START;
          PH_START:  phase_nxt = PH_WAIT;
          PH_WAIT: begin
            if (unit_done) begin
              phase_nxt = PH_SETTLE;
              unique case (state_r)
                S_ALLOC_MUL: state_nxt = (c_r == 2'd3) ? S_SQRT : S_ALLOC_MUL;
                S_SQRT:      state_nxt = S_OMSQ;
                S_OMSQ:      state_nxt = S_A2;
                S_A2:        state_nxt = S_A1;
                S_A1:        state_nxt = S_ADD0;
                S_DIV:       state_nxt = S_MIX_MUL;
                S_MIX_MUL: begin
                  if (c_r != 2'd3) begin
                    state_nxt = S_MIX_MUL;
                  end else begin
                    state_nxt = last_rotor ? S_DONE : S_ALLOC_MUL;
                  end
                end
                default:     state_nxt = S_IDLE;
              endcase
            end
          end
          default: phase_nxt = PH_SETTLE;
        endcase
      end
    endcase
  end

  always_comb begin
    in_ready      = (state_r == S_IDLE);
    mul_req.start = 1'b0;
    mul_req.shift = SH_8;
    mul_a         = ext48(alloc_rd_r);
    mul_b         = ext32(w_r[c_r]);
    sqrt_start    = 1'b0;
    div_start     = 1'b0;
    unit_done     = 1'b0;
    unique case (state_r)
      S_ALLOC_MUL: begin
        mul_req.start = issue;
        unit_done     = mul_rsp.done;
      end
      S_OMSQ: begin
        mul_req.start = issue;
        mul_a         = $signed({32'd0, om_r});
        mul_b         = $signed({32'd0, om_r});
        unit_done     = mul_rsp.done;
      end
      S_A2: begin
        mul_req.start = issue;
        mul_req.shift = SH_24;
        mul_a         = ext48(pwm_a2_r);
        mul_b         = omsq_r;
        unit_done     = mul_rsp.done;
      end
      S_A1: begin
        mul_req.start = issue;
        mul_req.shift = SH_16;
        mul_a         = ext48(pwm_a1_r);
        mul_b         = $signed({32'd0, om_r});
        unit_done     = mul_rsp.done;
      end
      S_MIX_MUL: begin
        mul_req.start = issue;
        mul_req.shift = SH_24;
        mul_a         = ext48(mix_rd_r);
        mul_b         = thr_r;
        unit_done     = mul_rsp.done;
      end
      S_SQRT: begin
        sqrt_start = issue;
        unit_done  = sqrt_done;
      end
      S_DIV: begin
        div_start = issue;
        unit_done = div_rsp.done;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_ALLOC_MUL: s_sum = sat_add(sq_r, mul_p);
      S_A1:        s_sum = sat_add(pwm_r, mul_p);
      S_ADD0:      s_sum = sat_add(pwm_r, ext48(pwm_a0_r));
      S_ADD1:      s_sum = sat_add(pwm_r, 64'sd0 - ext48(pwm_min_r));
      S_MIX_MUL:   s_sum = sat_add(acc_r[c_r], mul_p);
      default:     s_sum = sat_add(sq_r, mul_p);
    endcase
  end

  assign cl_roll   = clamp32(acc_r[0]);
  assign cl_pitch  = clamp32(acc_r[1]);
  assign cl_yaw    = clamp32(acc_r[2]);
  assign cl_thrust = clamp32(acc_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      phase_r       <= PH_SETTLE;
      out_valid_r   <= 1'b0;
      rotor_count_r <= 4'd4;
      pwm_a2_r      <= '0;
      pwm_a1_r      <= 48'd16777216;
      pwm_a0_r      <= '0;
      pwm_min_r     <= '0;
      pwm_max_r     <= 48'd16777216;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROTOR_COUNT: rotor_count_r <= cfg_wdata[3:0];
          CFG_PWM_A2:      pwm_a2_r      <= cfg_wdata;
          CFG_PWM_A1:      pwm_a1_r      <= cfg_wdata;
          CFG_PWM_A0:      pwm_a0_r      <= cfg_wdata;
          CFG_PWM_MIN:     pwm_min_r     <= cfg_wdata;
          CFG_PWM_MAX:     pwm_max_r     <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && idx_ok && in_kind == KIND_ALLOC) begin
      alloc_mem[wr_addr] <= in_coef_value;
    end
    if (accept && idx_ok && in_kind == KIND_MIX) begin
      mix_mem[wr_addr] <= in_coef_value;
    end
    alloc_rd_r <= alloc_mem[rd_addr];
    mix_rd_r   <= mix_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_kind == KIND_WRENCH) begin
          w_r[0] <= in_roll_torque;
          w_r[1] <= in_pitch_torque;
          w_r[2] <= in_yaw_torque;
          w_r[3] <= in_thrust_force;
          n_r    <= n_in;
          r_r    <= '0;
          c_r    <= '0;
          den_r  <= ext48(pwm_max_r) - ext48(pwm_min_r);
          sq_r   <= '0;
          sat_r  <= 1'b0;
          for (int i = 0; i < 4; i++) begin
            acc_r[i] <= '0;
          end
        end
      end
      S_ALLOC_MUL: begin
        if (phase_r == PH_WAIT && unit_done) begin
          sq_r  <= s_sum.val;
          sat_r <= sat_r | s_sum.sat | mul_rsp.sat;
          c_r   <= c_r + 2'd1;
        end
      end
      S_SQRT: begin
        if (phase_r == PH_WAIT && unit_done) begin
          om_r <= sqrt_root;
        end
      end
      S_OMSQ: begin
        if (phase_r == PH_WAIT && unit_done) begin
          omsq_r <= mul_p;
          sat_r  <= sat_r | mul_rsp.sat;
        end
      end
      S_A2: begin
        if (phase_r == PH_WAIT && unit_done) begin
          pwm_r <= mul_p;
          sat_r <= sat_r | mul_rsp.sat;
        end
      end
      S_A1: begin
        if (phase_r == PH_WAIT && unit_done) begin
          pwm_r <= s_sum.val;
          sat_r <= sat_r | s_sum.sat | mul_rsp.sat;
        end
      end
      S_ADD0, S_ADD1: begin
        pwm_r <= s_sum.val;
        sat_r <= sat_r | s_sum.sat;
      end
      S_DIV: begin
        if (phase_r == PH_WAIT && unit_done) begin
          thr_r <= div_q;
          sat_r <= sat_r | div_rsp.sat;
        end
      end
      S_MIX_MUL: begin
        if (phase_r == PH_WAIT && unit_done) begin
          acc_r[c_r] <= s_sum.val;
          sat_r      <= sat_r | s_sum.sat | mul_rsp.sat;
          c_r        <= c_r + 2'd1;
          if (c_r == 2'd3) begin
            r_r  <= ROT_W'(r_r + 1'b1);
            sq_r <= '0;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_roll_r   <= cl_roll.val;
          out_pitch_r  <= cl_pitch.val;
          out_yaw_r    <= cl_yaw.val;
          out_thrust_r <= cl_thrust.val;
          out_sat_r    <= sat_r | cl_roll.sat | cl_pitch.sat | cl_yaw.sat | cl_thrust.sat;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_norm_roll   = out_roll_r;
  assign out_norm_pitch  = out_pitch_r;
  assign out_norm_yaw    = out_yaw_r;
  assign out_norm_thrust = out_thrust_r;
  assign out_saturated   = out_sat_r;

endmodule
